FILE: hdl/pdmc_pkg.sv
// ----------------------------------------------------------------------------
// pdmc_pkg
// Shared types and constants of the PD motor position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdmc_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int SPEED_BITS_DEF    = 16;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRIVE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_OFFSET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_CORRECTION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WINDOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_POLLS      = 3'd7;

  localparam logic [15:0]        P_GAIN_RST          = 16'd655;
  localparam logic [15:0]        D_GAIN_RST          = 16'd6554;
  localparam logic [16:0]        MIN_DRIVE_RST       = 17'd9830;
  localparam logic [15:0]        PWM_TOP_RST         = 16'd4000;
  localparam logic [15:0]        HOME_OFFSET_RST     = 16'd30;
  localparam logic signed [15:0] HOME_CORRECTION_RST = 16'sd0;
  localparam logic [15:0]        TARGET_WINDOW_RST   = 16'd10;
  localparam logic [7:0]         STOP_POLLS_RST      = 8'd10;

  localparam logic [2:0] REQ_ENC    = 3'd0;
  localparam logic [2:0] REQ_TICK   = 3'd1;
  localparam logic [2:0] REQ_TARGET = 3'd2;
  localparam logic [2:0] REQ_HOME   = 3'd3;
  localparam logic [2:0] REQ_POLL   = 3'd4;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [7:0]  STALL_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]         req_type;
    logic               enc_a;
    logic               enc_b;
    logic signed [31:0] target_value;
  } pdmc_in_t;

  typedef struct packed {
    logic [15:0]        pwm_duty;
    logic               direction;
    logic signed [31:0] position_now;
    logic               at_target;
    logic               homing_busy;
  } pdmc_out_t;

  typedef struct packed {
    logic accept;
    logic exec_en;
    logic err_en;
    logic mul_en;
    logic sum_en;
    logic mag_en;
    logic lim_en;
    logic duty_en;
    logic out_load;
  } pdmc_cmd_t;

  typedef struct packed {
    logic is_tick;
  } pdmc_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ERR,
    ST_MUL,
    ST_SUM,
    ST_MAG,
    ST_LIM,
    ST_DUTY,
    ST_CMP
  } pdmc_state_t;

endpackage

`default_nettype wire

FILE: hdl/pdmc_ctrl.sv
// ----------------------------------------------------------------------------
// pdmc_ctrl
// Sequencer: takes requests, steps the datapath through the update and the
// drive computation, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_ctrl
  import pdmc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire pdmc_stat_t stat,
  output pdmc_cmd_t       cmd
);

  pdmc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec_en = 1'b1;
        if (stat.is_tick) begin
          cmd.err_en = 1'b1;
          state_nxt  = ST_MUL;
        end else begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag_en = 1'b1;
        state_nxt  = ST_LIM;
      end
      ST_LIM: begin
        cmd.lim_en = 1'b1;
        state_nxt  = ST_DUTY;
      end
      ST_DUTY: begin
        cmd.duty_en = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending request");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted request not executed");

  a_cmp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && out_valid_r && out_stall) |=> (state_r == ST_CMP && out_valid_r))
    else $error("result dropped while output stalled");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_en, cmd.sum_en, cmd.mag_en, cmd.lim_en, cmd.duty_en, cmd.out_load}))
    else $error("more than one datapath step at once");

endmodule

`default_nettype wire

FILE: hdl/pdmc_dp.sv
// ----------------------------------------------------------------------------
// pdmc_dp
// Datapath: configuration registers, position and homing state, the PD drive
// chain (multiply, sum, magnitude, limit, duty scale) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_dp
  import pdmc_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int SPEED_BITS    = SPEED_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire pdmc_in_t             in_data,
  input  wire pdmc_cmd_t            cmd,
  output pdmc_stat_t                stat,
  output pdmc_out_t                 out_data
);

  localparam int HALF  = (POSITION_BITS + 1) / 2;
  localparam int EXT_W = 2 * HALF;
  localparam int SW    = (POSITION_BITS > SPEED_BITS) ? POSITION_BITS : SPEED_BITS;
  localparam int DRV_W = ((EXT_W > SPEED_BITS) ? EXT_W : SPEED_BITS) + 19;
  localparam int CMP_W = POSITION_BITS + 2;

  logic [15:0]        p_gain_r, d_gain_r, pwm_top_r, home_offset_r, target_window_r;
  logic [16:0]        min_drive_r;
  logic signed [15:0] home_corr_r;
  logic [7:0]         stop_polls_r;

  logic [2:0]         req_r;
  logic               enc_up_r;
  logic signed [31:0] tval_r;

  logic [POSITION_BITS-1:0] position_r, position_nxt;
  logic [POSITION_BITS-1:0] prev_r, prev_nxt;
  logic [POSITION_BITS-1:0] target_r, target_nxt;
  logic signed [SPEED_BITS-1:0] speed_r, speed_nxt;
  logic                     homing_r, homing_nxt;
  logic [7:0]               stall_r, stall_nxt;
  logic [15:0]              duty_r;
  logic                     dir_r;

  logic signed [POSITION_BITS-1:0] err_r;
  logic [16+HALF-1:0]              prod_lo_r;
  logic signed [17+HALF-1:0]       prod_hi_r;
  logic signed [17+SPEED_BITS-1:0] prod_d_r;
  logic signed [DRV_W-1:0]         drive_r;
  logic [18:0]                     mag_r;
  logic [16:0]                     lim_r;
  pdmc_out_t                       out_r;

  logic [SW-1:0]            spd_diff;
  logic [7:0]               stall_inc;
  logic                     home_done;
  logic [POSITION_BITS-1:0] home_tgt, preset;

  logic signed [EXT_W-1:0]    err_ext;
  logic [HALF-1:0]            err_lo;
  logic signed [HALF-1:0]     err_hi;
  logic signed [DRV_W-1:0]    hi_ext, lo_ext, d_ext;
  logic [DRV_W-1:0]           mag_full;
  logic [18:0]                thr, raised;
  logic [16:0]                lim_nxt;
  logic [32:0]                duty_prod;
  logic signed [CMP_W-1:0]    e_x, w_x;
  logic                       at_tgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r        <= P_GAIN_RST;
      d_gain_r        <= D_GAIN_RST;
      min_drive_r     <= MIN_DRIVE_RST;
      pwm_top_r       <= PWM_TOP_RST;
      home_offset_r   <= HOME_OFFSET_RST;
      home_corr_r     <= HOME_CORRECTION_RST;
      target_window_r <= TARGET_WINDOW_RST;
      stop_polls_r    <= STOP_POLLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_P_GAIN:          p_gain_r        <= cfg_wdata[15:0];
        CFG_D_GAIN:          d_gain_r        <= cfg_wdata[15:0];
        CFG_MIN_DRIVE:       min_drive_r     <= cfg_wdata;
        CFG_PWM_TOP:         pwm_top_r       <= cfg_wdata[15:0];
        CFG_HOME_OFFSET:     home_offset_r   <= cfg_wdata[15:0];
        CFG_HOME_CORRECTION: home_corr_r     <= $signed(cfg_wdata[15:0]);
        CFG_TARGET_WINDOW:   target_window_r <= cfg_wdata[15:0];
        CFG_STOP_POLLS:      stop_polls_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_data.req_type;
      enc_up_r <= in_data.enc_a ^ in_data.enc_b;
      tval_r   <= in_data.target_value;
    end
  end

  assign spd_diff  = SW'(position_r) - SW'(prev_r);
  assign stall_inc = (speed_r == '0) ? ((stall_r == STALL_MAX) ? stall_r : stall_r + 8'd1)
                                     : 8'd0;
  assign home_done = (stall_inc >= stop_polls_r);
  assign home_tgt  = position_r - POSITION_BITS'(home_offset_r);
  assign preset    = POSITION_BITS'(0) - POSITION_BITS'(home_corr_r);

  always_comb begin
    position_nxt = position_r;
    prev_nxt     = prev_r;
    target_nxt   = target_r;
    speed_nxt    = speed_r;
    homing_nxt   = homing_r;
    stall_nxt    = stall_r;
    if (cmd.exec_en) begin
      unique case (req_r)
        REQ_ENC: begin
          position_nxt = enc_up_r ? position_r + POSITION_BITS'(1)
                                  : position_r - POSITION_BITS'(1);
        end
        REQ_TICK: begin
          speed_nxt = $signed(spd_diff[SPEED_BITS-1:0]);
          prev_nxt  = position_r;
        end
        REQ_TARGET: target_nxt = POSITION_BITS'(tval_r);
        REQ_HOME: begin
          homing_nxt = 1'b1;
          stall_nxt  = 8'd0;
        end
        REQ_POLL: begin
          if (homing_r) begin
            target_nxt = home_tgt;
            stall_nxt  = stall_inc;
            if (home_done) begin
              position_nxt = preset;
              target_nxt   = '0;
              prev_nxt     = '0;
              homing_nxt   = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      prev_r     <= '0;
      target_r   <= '0;
      speed_r    <= '0;
      homing_r   <= 1'b0;
      stall_r    <= 8'd0;
      duty_r     <= 16'd0;
      dir_r      <= 1'b0;
    end else begin
      position_r <= position_nxt;
      prev_r     <= prev_nxt;
      target_r   <= target_nxt;
      speed_r    <= speed_nxt;
      homing_r   <= homing_nxt;
      stall_r    <= stall_nxt;
      if (cmd.mag_en) begin
        dir_r <= drive_r[DRV_W-1];
      end
      if (cmd.duty_en) begin
        duty_r <= duty_prod[31:16];
      end
    end
  end

  assign err_ext = EXT_W'(err_r);
  assign err_lo  = err_ext[HALF-1:0];
  assign err_hi  = $signed(err_ext[EXT_W-1:HALF]);

  assign hi_ext = DRV_W'(prod_hi_r);
  assign lo_ext = DRV_W'(prod_lo_r);
  assign d_ext  = DRV_W'(prod_d_r);

  assign mag_full = drive_r[DRV_W-1] ? DRV_W'(-drive_r) : DRV_W'(drive_r);

  assign thr    = {1'b0, p_gain_r, 2'b00};
  assign raised = (mag_r < 19'(min_drive_r)) ? 19'(min_drive_r) : mag_r;

  always_comb begin
    if (mag_r < thr) begin
      lim_nxt = 17'd0;
    end else if (raised > 19'(ONE_Q16)) begin
      lim_nxt = ONE_Q16;
    end else begin
      lim_nxt = raised[16:0];
    end
  end

  assign duty_prod = 33'(lim_r) * 33'(pwm_top_r);

  always_ff @(posedge clk) begin
    if (cmd.err_en) begin
      err_r <= $signed(target_r - position_r);
    end
    if (cmd.mul_en) begin
      prod_lo_r <= p_gain_r * err_lo;
      prod_hi_r <= $signed({1'b0, p_gain_r}) * err_hi;
      prod_d_r  <= $signed({1'b0, d_gain_r}) * speed_r;
    end
    if (cmd.sum_en) begin
      drive_r <= (hi_ext <<< HALF) + lo_ext - d_ext;
    end
    if (cmd.mag_en) begin
      mag_r <= (|mag_full[DRV_W-1:19]) ? '1 : mag_full[18:0];
    end
    if (cmd.lim_en) begin
      lim_r <= lim_nxt;
    end
  end

  assign e_x    = CMP_W'(err_r);
  assign w_x    = CMP_W'({1'b0, target_window_r});
  assign at_tgt = (e_x < w_x) && (e_x > -w_x);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= '{pwm_duty:     duty_r,
                 direction:    dir_r,
                 position_now: 32'(position_r),
                 at_target:    at_tgt,
                 homing_busy:  homing_r};
    end
  end

  assign stat.is_tick = (req_r == REQ_TICK);
  assign out_data     = out_r;

  a_lim_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.duty_en |-> (lim_r <= ONE_Q16))
    else $error("drive magnitude above full scale");

  a_home_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_en && req_r == REQ_POLL && homing_r && home_done)
      |=> (!homing_r && target_r == '0 && prev_r == '0))
    else $error("homing did not finish cleanly");

endmodule

`default_nettype wire

FILE: hdl/pd_motor_position_controller.sv
// ----------------------------------------------------------------------------
// pd_motor_position_controller
// Encoder position loop with PD drive, PWM duty output and stall homing.
// Requests step through exec, error and compare; a control tick runs the
// sequencer through exec, multiply, sum, magnitude, limit, scale and compare.
// The sequencer takes a new request only once it is back in idle.
// A stalled result holds the sequencer; the next request waits meanwhile.
// Reset: synchronous; state zero, registers to their defaults, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_motor_position_controller
  import pdmc_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int SPEED_BITS    = SPEED_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pdmc_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pdmc_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  pdmc_cmd_t  cmd;
  pdmc_stat_t stat;

  pdmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdmc_dp #(
    .POSITION_BITS (POSITION_BITS),
    .SPEED_BITS    (SPEED_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PD motor position controller. A scoreboard
// class tracks encoder position, target, speed, homing and the held drive,
// predicts one result per accepted request and compares every field of the
// results as they drain. Traffic mixes encoder bursts, control ticks, target
// loads and full homing sequences over several register settings, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------

module testbench;
  import pdmc_pkg::*;

  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASES         = 8;

  class pdmc_scoreboard;
    logic [15:0]        p_gain, d_gain, pwm_top, home_offset, target_window;
    logic [16:0]        min_drive;
    logic signed [15:0] home_correction;
    logic [7:0]         stop_polls;
    logic [31:0]        position, prev_position, target;
    logic [15:0]        speed;
    bit                 homing;
    logic [7:0]         stall_run;
    logic [15:0]        duty_hold;
    bit                 dir_hold;
    pdmc_out_t          expected_q[$];
    int                 fails;

    function new();
      p_gain          = P_GAIN_RST;
      d_gain          = D_GAIN_RST;
      min_drive       = MIN_DRIVE_RST;
      pwm_top         = PWM_TOP_RST;
      home_offset     = HOME_OFFSET_RST;
      home_correction = HOME_CORRECTION_RST;
      target_window   = TARGET_WINDOW_RST;
      stop_polls      = STOP_POLLS_RST;
      position        = '0;
      prev_position   = '0;
      target          = '0;
      speed           = '0;
      homing          = 1'b0;
      stall_run       = '0;
      duty_hold       = '0;
      dir_hold        = 1'b0;
      fails           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_P_GAIN:          p_gain = value[15:0];
        CFG_D_GAIN:          d_gain = value[15:0];
        CFG_MIN_DRIVE:       min_drive = value;
        CFG_PWM_TOP:         pwm_top = value[15:0];
        CFG_HOME_OFFSET:     home_offset = value[15:0];
        CFG_HOME_CORRECTION: home_correction = value[15:0];
        CFG_TARGET_WINDOW:   target_window = value[15:0];
        CFG_STOP_POLLS:      stop_polls = value[7:0];
        default: ;
      endcase
    endfunction

    function void update_drive();
      logic [31:0] moved;
      longint      err, spd, drive, mag, scaled;
      moved         = position - prev_position;
      speed         = moved[15:0];
      prev_position = position;
      err   = longint'($signed(target - position));
      spd   = longint'($signed(speed));
      drive = longint'(p_gain) * err - longint'(d_gain) * spd;
      dir_hold = drive < 0;
      mag      = dir_hold ? -drive : drive;
      if (mag < 4 * longint'(p_gain)) begin
        mag = 0;
      end else begin
        if (mag < longint'(min_drive)) mag = longint'(min_drive);
        if (mag > longint'(ONE_Q16)) mag = longint'(ONE_Q16);
      end
      scaled    = mag * longint'(pwm_top);
      duty_hold = scaled[31:16];
    endfunction

    function void homing_step();
      if (!homing) return;
      target = position - home_offset;
      if (speed == '0) begin
        if (stall_run != STALL_MAX) stall_run++;
      end else begin
        stall_run = '0;
      end
      if (stall_run >= stop_polls) begin
        position      = 32'd0 - {{16{home_correction[15]}}, home_correction};
        target        = '0;
        prev_position = '0;
        homing        = 1'b0;
      end
    endfunction

    function void note_request(pdmc_in_t req);
      pdmc_out_t exp;
      longint    err;
      case (req.req_type)
        REQ_ENC:    position = (req.enc_a ^ req.enc_b) ? position + 1 : position - 1;
        REQ_TICK:   update_drive();
        REQ_TARGET: target = req.target_value;
        REQ_HOME: begin
          homing    = 1'b1;
          stall_run = '0;
        end
        REQ_POLL:   homing_step();
        default: ;
      endcase
      err = longint'($signed(target - position));
      if (err < 0) err = -err;
      exp.pwm_duty     = duty_hold;
      exp.direction    = dir_hold;
      exp.position_now = position;
      exp.at_target    = err < longint'(target_window);
      exp.homing_busy  = homing;
      expected_q.push_back(exp);
    endfunction

    function void check_result(pdmc_out_t got);
      pdmc_out_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %p", got);
        fails++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.pwm_duty !== exp.pwm_duty) begin
        $error("pwm_duty: expected %0d, got %0d", exp.pwm_duty, got.pwm_duty);
        fails++;
      end
      if (got.direction !== exp.direction) begin
        $error("direction: expected %0b, got %0b", exp.direction, got.direction);
        fails++;
      end
      if (got.position_now !== exp.position_now) begin
        $error("position_now: expected %0d, got %0d", exp.position_now, got.position_now);
        fails++;
      end
      if (got.at_target !== exp.at_target) begin
        $error("at_target: expected %0b, got %0b", exp.at_target, got.at_target);
        fails++;
      end
      if (got.homing_busy !== exp.homing_busy) begin
        $error("homing_busy: expected %0b, got %0b", exp.homing_busy, got.homing_busy);
        fails++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  pdmc_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pdmc_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  pdmc_scoreboard sb = new();
  bit idle_on      = 1'b1;
  int stall_left   = 0;
  int work_items   = 0;
  int quiet_cycles = 0;

  pd_motor_position_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic pdmc_in_t make_item(logic [2:0] kind, logic a, logic b,
                                         logic [31:0] value);
    pdmc_in_t item;
    item.req_type     = kind;
    item.enc_a        = a;
    item.enc_b        = b;
    item.target_value = value;
    return item;
  endfunction

  task automatic send(pdmc_in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    if (!(item.req_type > REQ_POLL || (item.req_type == REQ_POLL && !sb.homing)))
      work_items++;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_setting(logic [15:0] p, logic [15:0] d, logic [16:0] floor_drive,
                              logic [15:0] top, logic [15:0] offset, logic [15:0] corr,
                              logic [15:0] window, logic [7:0] polls);
    write_reg(CFG_P_GAIN, p);
    write_reg(CFG_D_GAIN, d);
    write_reg(CFG_MIN_DRIVE, floor_drive);
    write_reg(CFG_PWM_TOP, top);
    write_reg(CFG_HOME_OFFSET, offset);
    write_reg(CFG_HOME_CORRECTION, corr);
    write_reg(CFG_TARGET_WINDOW, window);
    write_reg(CFG_STOP_POLLS, polls);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(int quota, bit calm);
    int unsigned k, dir_bit, a_bit, polls, moves;
    logic [31:0] aim;
    quota = work_items + quota;
    while (work_items < quota) begin
      idle_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          k       = $urandom_range(0, 6);
          dir_bit = $urandom_range(0, 1);
          repeat (k) begin
            a_bit = $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0)
              send(make_item(REQ_ENC, a_bit, $urandom_range(0, 1), $urandom()));
            else
              send(make_item(REQ_ENC, a_bit, a_bit ^ dir_bit, $urandom()));
          end
          send(make_item(REQ_TICK, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
        end
        4, 8: begin
          if ($urandom_range(0, 3) == 0) aim = $urandom();
          else aim = sb.position + 32'($urandom_range(0, 80)) - 32'd40;
          send(make_item(REQ_TARGET, $urandom_range(0, 1), $urandom_range(0, 1), aim));
          repeat ($urandom_range(1, 3))
            send(make_item(REQ_TICK, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
        end
        5, 6: begin
          send(make_item(REQ_HOME, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
          polls = (int'(sb.stop_polls) + 2 > 16) ? 16 : int'(sb.stop_polls) + 2;
          for (int i = 0; i < polls && sb.homing; i++) begin
            moves = (i < 2) ? $urandom_range(0, 3) : ($urandom_range(0, 5) == 0);
            repeat (moves)
              send(make_item(REQ_ENC, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
            send(make_item(REQ_TICK, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
            case ($urandom_range(0, 11))
              0: send(make_item(REQ_TARGET, $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom()));
              1: send(make_item(REQ_HOME, $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom()));
              default: ;
            endcase
            send(make_item(REQ_POLL, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
          end
        end
        7: begin
          if ($urandom_range(0, 1) == 0)
            send(make_item(REQ_POLL, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
          else
            send(make_item($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST),
                           $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0)
              send(make_item(REQ_ENC, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
            send(make_item(REQ_TICK, $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(make_item(REQ_ENC, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_ENC, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send(make_item(REQ_ENC, 1'b0, 1'b1, 32'h0));
    send(make_item(REQ_ENC, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_TARGET, 1'b1, 1'b1, 32'h7FFF_FFFF));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_TARGET, 1'b0, 1'b0, 32'h8000_0000));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_TARGET, 1'b0, 1'b0, 32'd3));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_TARGET, 1'b0, 1'b0, 32'd20));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_TARGET, 1'b0, 1'b0, 32'd8));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    repeat (3) send(make_item(REQ_ENC, 1'b1, 1'b0, 32'h0));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_POLL, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_HOME, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_POLL, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_HOME, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_TARGET, 1'b0, 1'b0, 32'd1234));
    send(make_item(REQ_TICK, 1'b0, 1'b0, 32'h0));
    send(make_item(REQ_POLL, 1'b0, 1'b0, 32'h0));
    for (int s = REQ_SPARE_FIRST; s <= REQ_SPARE_LAST; s++)
      send(make_item(s, 1'b1, 1'b1, 32'h5A5A_A5A5));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: ;
        1: load_setting(16'hFFFF, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                        16'hFFFF, 8'hFF);
        2: load_setting(16'h0, 16'h0, 17'h0, 16'd1, 16'h0, 16'h7FFF, 16'h0, 8'h0);
        3: load_setting(16'd300, 16'd3000, 17'h10000, 16'd0, 16'd5, 16'hFFF6, 16'd3, 8'd1);
        default: load_setting(
          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20000),
          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 20000),
          $urandom_range(0, 65535), $urandom_range(0, 100), $urandom(),
          $urandom_range(0, 200), $urandom_range(0, 12));
      endcase
      run_traffic(PHASE_ITEMS, ph == PHASES - 1);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
